// ===== rtl/assert_macros.svh =====
// Assertion macros used by the range statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`endif
`ifndef NO_ASSERTIONS
`define ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/srss_pkg.sv =====
// Package with types, codes and conversion helpers for the range statistics scan.
package srss_pkg;

    localparam logic [3:0] TYPE_U8  = 4'd0;
    localparam logic [3:0] TYPE_U16 = 4'd1;
    localparam logic [3:0] TYPE_U32 = 4'd2;
    localparam logic [3:0] TYPE_U64 = 4'd3;
    localparam logic [3:0] TYPE_I8  = 4'd4;
    localparam logic [3:0] TYPE_I16 = 4'd5;
    localparam logic [3:0] TYPE_I32 = 4'd6;
    localparam logic [3:0] TYPE_I64 = 4'd7;
    localparam logic [3:0] TYPE_F16 = 4'd8;
    localparam logic [3:0] TYPE_F32 = 4'd9;
    localparam logic [3:0] TYPE_F64 = 4'd10;

    localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] POS_ZERO = 64'h0;

    // Register index, taken from byte address bit 3 (registers sit 8 bytes apart).
    localparam logic ADDR_TYPE   = 1'b0;
    localparam logic ADDR_NODATA = 1'b1;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
        logic [63:0] min_mag;
        logic [63:0] max_mag;
        logic        neg;
        logic        fin;
    } stats_t;

    // Total order key for finite binary64: negative values flipped fully.
    function automatic logic [63:0] order_key(input logic [63:0] b);
        order_key = b[63] ? ~b : {1'b1, b[62:0]};
    endfunction

    // Less-than on binary64 patterns that treats +0 and -0 as equal.
    function automatic logic f64_lt(input logic [63:0] a, input logic [63:0] b);
        logic both_zero;
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        f64_lt = !both_zero && (order_key(a) < order_key(b));
    endfunction

    // 64-bit magnitude to binary64 with round to nearest even.
    function automatic logic [62:0] mag_to_f64(input logic [63:0] m);
        logic [5:0]  lz;
        logic [63:0] norm;
        logic [52:0] mant;
        logic        rnd;
        logic        stk;
        logic [53:0] sum;
        logic [10:0] expo;
        lz = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                lz = 6'(63 - i);
            end
        end
        norm = m << lz;
        mant = norm[63:11];
        rnd = norm[10];
        stk = |norm[9:0];
        sum = {1'b0, mant} + 54'(rnd && (stk || mant[0]));
        expo = 11'(1023 + 63) - 11'(lz);
        if (m == 64'd0) begin
            mag_to_f64 = 63'd0;
        end else if (sum[53]) begin
            mag_to_f64 = {expo + 11'd1, 52'd0};
        end else begin
            mag_to_f64 = {expo, sum[51:0]};
        end
    endfunction

endpackage

// ===== rtl/sample_range_statistics_scan.sv =====
// Top level of the running min, max and magnitude scan over raster samples.
//   channel | direction | content
//   s_axis  | in        | one sample and its end-of-tile mark
//   m_axis  | out       | tile statistics, one result per tile
//   apb     | in        | sample type and nodata sentinel registers
// One sample is taken per clock while s_tready is high; the tile result is
// held in an output register until taken. The sample path is an input register,
// conversion and compare logic, then the running registers. Reset (aresetn low,
// synchronous) clears the configuration registers, valid flags and statistics.
// While the output register is full and not taken, a new last sample stalls.
`include "assert_macros.svh"
module sample_range_statistics_scan (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [63:0] sample_bits
    input  logic         s_tlast,   // last_sample
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata,   // lowest, highest, least_nonzero, greatest
    output logic [1:0]   m_tuser,   // [0] saw_negative, [1] saw_finite
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [3:0]  type_reg;
    logic [63:0] nodata_reg;
    logic        in_valid_reg;
    logic [63:0] in_bits_reg;
    logic        in_last_reg;
    srss_pkg::stats_t run_reg, run_next, upd;
    logic        out_valid_reg;
    srss_pkg::stats_t out_reg;

    logic [63:0] mask;
    logic [63:0] raw;
    logic        known;
    logic        skip;
    logic [63:0] val;
    logic [63:0] mag;
    logic [63:0] sext;
    logic        sgn;
    logic [63:0] abs_i;
    logic        fin;
    logic        stall;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_reg <= 4'd0;
            nodata_reg <= 64'd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3])
                srss_pkg::ADDR_TYPE:   type_reg <= pwdata[3:0];
                srss_pkg::ADDR_NODATA: nodata_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            srss_pkg::ADDR_TYPE:   prdata = {60'd0, type_reg};
            srss_pkg::ADDR_NODATA: prdata = nodata_reg;
            default:               prdata = 64'd0;
        endcase
    end

    // The input stage stalls only when a last sample meets a full, untaken output.
    assign stall = in_valid_reg && in_last_reg && out_valid_reg && !m_tready;
    assign s_tready = !stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (!stall) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            in_bits_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Element masking and type check.
    always_comb begin
        known = 1'b1;
        case (type_reg)
            srss_pkg::TYPE_U8, srss_pkg::TYPE_I8:                     mask = 64'hFF;
            srss_pkg::TYPE_U16, srss_pkg::TYPE_I16, srss_pkg::TYPE_F16: mask = 64'hFFFF;
            srss_pkg::TYPE_U32, srss_pkg::TYPE_I32, srss_pkg::TYPE_F32: mask = 64'hFFFF_FFFF;
            srss_pkg::TYPE_U64, srss_pkg::TYPE_I64, srss_pkg::TYPE_F64: mask = '1;
            default: begin
                mask = '1;
                known = 1'b0;
            end
        endcase
        raw = in_bits_reg & mask;
    end

    // Widening to binary64, sentinel and finite test.
    always_comb begin
        sext = raw;
        case (type_reg)
            srss_pkg::TYPE_I8:  sext = {{56{raw[7]}}, raw[7:0]};
            srss_pkg::TYPE_I16: sext = {{48{raw[15]}}, raw[15:0]};
            srss_pkg::TYPE_I32: sext = {{32{raw[31]}}, raw[31:0]};
            default:            sext = raw;
        endcase
        sgn = (type_reg inside {[srss_pkg::TYPE_I8:srss_pkg::TYPE_I64]}) && sext[63];
        abs_i = sgn ? (~sext + 64'd1) : sext;
        val = {sgn, srss_pkg::mag_to_f64(abs_i)};
        case (type_reg)
            srss_pkg::TYPE_F16: begin
                if (raw[14:10] == 5'h1F) begin
                    val = {raw[15], 11'h7FF, raw[9:0], 42'd0};
                end else if (raw[14:10] == 5'd0) begin
                    val = {raw[15], srss_pkg::mag_to_f64({54'd0, raw[9:0]}) -
                           63'({11'd24, 52'd0})};
                    if (raw[9:0] == 10'd0) begin
                        val = {raw[15], 63'd0};
                    end
                end else begin
                    val = {raw[15], 11'(raw[14:10]) + 11'd1008, raw[9:0], 42'd0};
                end
            end
            srss_pkg::TYPE_F32: begin
                if (raw[30:23] == 8'hFF) begin
                    val = {raw[31], 11'h7FF, raw[22:0], 29'd0};
                end else if (raw[30:23] == 8'd0) begin
                    val = {raw[31], srss_pkg::mag_to_f64({41'd0, raw[22:0]}) -
                           63'({11'd149, 52'd0})};
                    if (raw[22:0] == 23'd0) begin
                        val = {raw[31], 63'd0};
                    end
                end else begin
                    val = {raw[31], 11'(raw[30:23]) + 11'd896, raw[22:0], 29'd0};
                end
            end
            srss_pkg::TYPE_F64: val = raw;
            default: ;
        endcase
        fin = val[62:52] != 11'h7FF;
        skip = !known || (raw == (nodata_reg & mask)) || !fin;
        mag = {1'b0, val[62:0]};
    end

    // Running statistics update.
    always_comb begin
        upd = run_reg;
        if (!skip) begin
            upd.fin = 1'b1;
            if (srss_pkg::f64_lt(val, run_reg.low)) upd.low = val;
            if (srss_pkg::f64_lt(run_reg.high, val)) upd.high = val;
            if (val[63] && val[62:0] != 63'd0) upd.neg = 1'b1;
            if (mag[62:0] > run_reg.max_mag[62:0]) upd.max_mag = mag;
            if (mag[62:0] != 63'd0 && mag[62:0] < run_reg.min_mag[62:0]) upd.min_mag = mag;
        end
        run_next = run_reg;
        if (in_valid_reg && !stall) begin
            run_next = upd;
            if (in_last_reg) begin
                run_next = '{srss_pkg::POS_INF, srss_pkg::NEG_INF, srss_pkg::POS_INF,
                             srss_pkg::POS_ZERO, 1'b0, 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '{srss_pkg::POS_INF, srss_pkg::NEG_INF, srss_pkg::POS_INF,
                         srss_pkg::POS_ZERO, 1'b0, 1'b0};
        end else begin
            run_reg <= run_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_valid_reg && in_last_reg && !stall) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && in_last_reg && !stall) begin
            out_reg <= upd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {out_reg.max_mag, out_reg.min_mag, out_reg.high, out_reg.low};
    assign m_tuser = {out_reg.fin, out_reg.neg};

    `ASSERT_CLK(a_stall_full, aclk, aresetn, stall |-> out_valid_reg, "stall without full output")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
    `ASSERT_CLK(a_restart, aclk, aresetn,
        (in_valid_reg && in_last_reg && !stall) |=> !run_reg.fin, "stats not restarted")
    `ASSERT_CLK(a_neg_fin, aclk, aresetn, run_reg.neg |-> run_reg.fin, "negative without sample")

endmodule
